// File: rtl/owbm_pkg.sv
// Shared types, codes and timing constants of the one-wire bus master.
package owbm_pkg;

    // Command kinds.
    localparam logic [1:0] KIND_RESET = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Line drive codes.
    localparam logic [1:0] DRIVE_RELEASE = 2'd0;
    localparam logic [1:0] DRIVE_LOW     = 2'd1;
    localparam logic [1:0] DRIVE_HIGH    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TICKS_PER_US    = 2'd0;
    localparam logic [1:0] CFG_FAST_MODE       = 2'd1;
    localparam logic [1:0] CFG_LOW_PULSE_TICKS = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] RST_TICKS_PER_US    = 8'd100;
    localparam logic       RST_FAST_MODE       = 1'b0;
    localparam logic [7:0] RST_LOW_PULSE_TICKS = 8'd5;

    // Bus timing in microseconds.
    localparam logic [5:0] US_RST_LOW   = 6'd54;
    localparam logic [5:0] US_RST_WAIT  = 6'd9;
    localparam logic [5:0] US_RST_REC   = 6'd50;
    localparam logic [5:0] US_WR_LOW    = 6'd1;
    localparam logic [5:0] US_WR_SLOT   = 6'd10;
    localparam logic [5:0] US_WR_SLOT_F = 6'd8;
    localparam logic [5:0] US_WR_HIGH   = 6'd5;
    localparam logic [5:0] US_WR_HIGH_F = 6'd6;
    localparam logic [5:0] US_RD_WAIT   = 6'd5;
    localparam logic [5:0] US_RD_HIGH   = 6'd6;

    // Width of a phase duration: 54 us at 255 ticks/us fits.
    localparam int DUR_W = 14;

    // Saturation point of the vote counter.
    localparam logic [2:0] VOTE_CAP = 3'd7;

    typedef struct packed {
        logic       start;
        logic [1:0] kind;
        logic [7:0] write_data;
        logic       line_in;
    } t_item;

    typedef struct packed {
        logic [1:0] line_drive;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
    } t_result;

    // Ticks for n microseconds; a rate of zero counts as one.
    function automatic logic [DUR_W-1:0] us_dur(input logic [7:0] tpu, input logic [5:0] n);
        logic [7:0] t;
        t = (tpu == 8'd0) ? 8'd1 : tpu;
        return DUR_W'({6'b0, t} * {8'b0, n});
    endfunction

endpackage

// File: rtl/owbm_fifo.sv
// Two-entry queue used on both sides of the sequencer.
module owbm_fifo #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr <= ~r_wr;
            end
            if (pop_ok) begin
                r_rd <= ~r_rd;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// File: rtl/owbm_front.sv
// Front end: classify each tick's command and queue it for the sequencer.
module owbm_front
    import owbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic       i_cmd_valid,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_write_data,
    input  logic       i_line_in,
    input  logic       i_pop,
    output logic       o_empty,
    output t_item      o_item
);
    t_item item;

    // Clear the start flag of unknown kinds so the back end only starts real commands.
    always_comb begin
        item.start      = i_cmd_valid && (i_kind inside {KIND_RESET, KIND_WRITE, KIND_READ});
        item.kind       = i_kind;
        item.write_data = i_write_data;
        item.line_in    = i_line_in;
    end

    owbm_fifo #(
        .WIDTH($bits(t_item))
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_data (item),
        .o_full (o_full),
        .i_pop  (i_pop),
        .o_data (o_item),
        .o_empty(o_empty)
    );
endmodule

// File: rtl/owbm_core.sv
// Back end: bus slot sequencer, phase timer, shifter, vote counter and registers.
module owbm_core
    import owbm_pkg::*;
#(
    parameter int VOTE_SAMPLES  = 7,
    parameter int BITS_PER_BYTE = 8,
    parameter int TIMER_BITS    = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic       i_item_valid,
    output logic       o_item_pop,
    output t_result    o_res,
    output logic       o_res_push,
    input  logic       i_res_full,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
        PH_WR_LOW, PH_WR_SLOT, PH_WR_HIGH,
        PH_RD_LOW, PH_RD_REL, PH_RD_SAMPLE, PH_RD_WAIT, PH_RD_HIGH
    } t_phase;

    // Configuration and per-phase durations.
    logic [7:0]       r_tpu, n_tpu;
    logic             r_fast, n_fast;
    logic [7:0]       r_lpt, n_lpt;
    logic             cfg_wr;
    logic [7:0]       n_pulse;
    logic [DUR_W-1:0] r_len_rst_low, r_len_rst_wait, r_len_rst_rec;
    logic [DUR_W-1:0] r_len_wr_low, r_len_wr_slot, r_len_wr_high;
    logic [DUR_W-1:0] r_len_rd_low, r_len_rd_rel, r_len_rd_wait, r_len_rd_high;

    // Sequencer state.
    t_phase                r_phase, n_phase, st_phase;
    logic [1:0]            r_op, n_op, st_op;
    logic [TIMER_BITS-1:0] r_tm, n_tm, st_tm, tm_inc, len;
    logic [2:0]            r_bi, n_bi, st_bi;
    logic [7:0]            r_sb, n_sb, st_sb;
    logic [2:0]            r_vc, n_vc, st_vc;
    logic                  r_pres, n_pres;
    logic [7:0]            r_rhold, n_rhold;
    logic                  fire, busy, done, vbit;
    logic [1:0]            drive;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_comb begin
        n_tpu  = r_tpu;
        n_fast = r_fast;
        n_lpt  = r_lpt;
        if (!i_rst_n) begin
            n_tpu  = RST_TICKS_PER_US;
            n_fast = RST_FAST_MODE;
            n_lpt  = RST_LOW_PULSE_TICKS;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_TICKS_PER_US:    n_tpu  = i_cfg_data;
                CFG_FAST_MODE:       n_fast = i_cfg_data[0];
                CFG_LOW_PULSE_TICKS: n_lpt  = i_cfg_data;
                default:             n_tpu  = r_tpu;
            endcase
        end
        n_pulse = (n_lpt == 8'd0) ? 8'd1 : n_lpt;
    end

    always_ff @(posedge i_clk) begin
        r_tpu  <= n_tpu;
        r_fast <= n_fast;
        r_lpt  <= n_lpt;
    end

    // Precompute durations from the values the registers are about to hold.
    always_ff @(posedge i_clk) begin
        r_len_rst_low  <= us_dur(n_tpu, US_RST_LOW);
        r_len_rst_wait <= us_dur(n_tpu, US_RST_WAIT);
        r_len_rst_rec  <= us_dur(n_tpu, US_RST_REC);
        r_len_wr_low   <= n_fast ? DUR_W'(n_pulse) : us_dur(n_tpu, US_WR_LOW);
        r_len_wr_slot  <= us_dur(n_tpu, n_fast ? US_WR_SLOT_F : US_WR_SLOT);
        r_len_wr_high  <= us_dur(n_tpu, n_fast ? US_WR_HIGH_F : US_WR_HIGH);
        r_len_rd_low   <= DUR_W'(n_pulse);
        r_len_rd_rel   <= n_fast ? '0 : DUR_W'(n_tpu >> 1);
        r_len_rd_wait  <= us_dur(n_tpu, US_RD_WAIT);
        r_len_rd_high  <= us_dur(n_tpu, US_RD_HIGH);
    end

    assign fire       = i_item_valid && !i_res_full;
    assign o_item_pop = fire;
    assign o_res_push = fire;

    always_comb begin
        // Start a command only from idle.
        st_phase = r_phase;
        st_op    = r_op;
        st_tm    = r_tm;
        st_bi    = r_bi;
        st_sb    = r_sb;
        st_vc    = r_vc;
        if (r_phase == PH_IDLE && i_item.start) begin
            st_op = i_item.kind;
            st_tm = '0;
            st_bi = 3'd0;
            st_vc = 3'd0;
            st_sb = (i_item.kind == KIND_WRITE) ? i_item.write_data : 8'd0;
            case (i_item.kind)
                KIND_RESET: st_phase = PH_RST_LOW;
                KIND_WRITE: st_phase = PH_WR_LOW;
                default:    st_phase = PH_RD_LOW;
            endcase
        end
        busy = (st_phase != PH_IDLE);

        case (st_phase)
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive = DRIVE_LOW;
            PH_WR_SLOT:                       drive = st_sb[st_bi] ? DRIVE_HIGH : DRIVE_LOW;
            PH_WR_HIGH, PH_RD_HIGH:           drive = DRIVE_HIGH;
            default:                          drive = DRIVE_RELEASE;
        endcase

        case (st_phase)
            PH_RST_LOW:   len = TIMER_BITS'(r_len_rst_low);
            PH_RST_WAIT:  len = TIMER_BITS'(r_len_rst_wait);
            PH_RST_REC:   len = TIMER_BITS'(r_len_rst_rec);
            PH_WR_LOW:    len = TIMER_BITS'(r_len_wr_low);
            PH_WR_SLOT:   len = TIMER_BITS'(r_len_wr_slot);
            PH_WR_HIGH:   len = TIMER_BITS'(r_len_wr_high);
            PH_RD_LOW:    len = TIMER_BITS'(r_len_rd_low);
            PH_RD_REL:    len = TIMER_BITS'(r_len_rd_rel);
            PH_RD_SAMPLE: len = r_fast ? TIMER_BITS'(VOTE_SAMPLES) : TIMER_BITS'(1);
            PH_RD_WAIT:   len = TIMER_BITS'(r_len_rd_wait);
            PH_RD_HIGH:   len = TIMER_BITS'(r_len_rd_high);
            default:      len = TIMER_BITS'(1);
        endcase
        tm_inc = (st_tm == TIMER_MAX) ? st_tm : st_tm + TIMER_BITS'(1);

        n_phase = st_phase;
        n_op    = st_op;
        n_tm    = st_tm;
        n_bi    = st_bi;
        n_sb    = st_sb;
        n_vc    = st_vc;
        n_pres  = r_pres;
        n_rhold = r_rhold;
        done    = 1'b0;
        vbit    = 1'b0;

        if (busy) begin
            if (st_phase == PH_RST_REC && st_tm == '0) begin
                n_pres = !i_item.line_in;
            end
            if (st_phase == PH_RD_SAMPLE && st_vc != VOTE_CAP) begin
                n_vc = st_vc + {2'b0, i_item.line_in};
            end
            n_tm = tm_inc;
            vbit = r_fast ? (({1'b0, n_vc} + 4'd2) > 4'(VOTE_SAMPLES)) : (n_vc != 3'd0);
            if (tm_inc >= len) begin
                n_tm = '0;
                case (st_phase)
                    PH_RST_LOW:  n_phase = PH_RST_WAIT;
                    PH_RST_WAIT: n_phase = PH_RST_REC;
                    PH_RST_REC: begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end
                    PH_WR_LOW:   n_phase = PH_WR_SLOT;
                    PH_WR_SLOT:  n_phase = PH_WR_HIGH;
                    PH_RD_LOW: begin
                        n_phase = (r_len_rd_rel != '0) ? PH_RD_REL : PH_RD_SAMPLE;
                        n_vc    = 3'd0;
                    end
                    PH_RD_REL: begin
                        n_phase = PH_RD_SAMPLE;
                        n_vc    = 3'd0;
                    end
                    PH_RD_SAMPLE: begin
                        n_sb    = st_sb | (8'({7'd0, vbit}) << st_bi);
                        n_vc    = 3'd0;
                        n_phase = PH_RD_WAIT;
                    end
                    PH_RD_WAIT:  n_phase = PH_RD_HIGH;
                    PH_WR_HIGH, PH_RD_HIGH: begin
                        // Finish the byte or start its next bit.
                        if (({1'b0, st_bi} + 4'd1) >= 4'(BITS_PER_BYTE)) begin
                            if (st_op == KIND_READ) begin
                                n_rhold = st_sb;
                            end
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                        end else begin
                            n_bi    = st_bi + 3'd1;
                            n_phase = (st_op == KIND_WRITE) ? PH_WR_LOW : PH_RD_LOW;
                        end
                    end
                    default:     n_phase = PH_IDLE;
                endcase
            end
        end

        o_res.line_drive = drive;
        o_res.busy_res   = busy;
        o_res.done_res   = done;
        o_res.presence   = n_pres;
        o_res.read_data  = n_rhold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_op    <= 2'd0;
            r_tm    <= '0;
            r_bi    <= 3'd0;
            r_sb    <= 8'd0;
            r_vc    <= 3'd0;
            r_pres  <= 1'b0;
            r_rhold <= 8'd0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_op    <= n_op;
            r_tm    <= n_tm;
            r_bi    <= n_bi;
            r_sb    <= n_sb;
            r_vc    <= n_vc;
            r_pres  <= n_pres;
            r_rhold <= n_rhold;
        end
    end
endmodule

// File: rtl/one_wire_bus_master.sv
// Flow: a tick request waits in the input queue until the sequencer takes it; its
//   result is then written into the output queue behind any earlier results.
// Throughput: one tick per cycle while the result queue has room; the sequencer
//   does a tick's whole step per cycle and the two-entry queues keep both streaming.
// Reset: synchronous, active low; empties both queues, returns the sequencer
//   to idle and loads the default register values. cfg_ready is always high.
module one_wire_bus_master
    import owbm_pkg::*;
#(
    parameter int VOTE_SAMPLES  = 7,
    parameter int BITS_PER_BYTE = 8,
    parameter int TIMER_BITS    = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Tick requests in.
    input  logic       push,
    output logic       full,
    input  logic       i_cmd_valid,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_write_data,
    input  logic       i_line_in,
    // Tick results out.
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_line_drive,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_presence,
    output logic [7:0] o_read_data,
    // Register writes.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    t_item   item;
    logic    in_empty;
    logic    item_pop;
    t_result res;
    logic    res_push;
    logic    out_full;
    t_result out_res;

    // Front end: classify each tick and hold it until the sequencer takes it.
    owbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_cmd_valid (i_cmd_valid),
        .i_kind      (i_kind),
        .i_write_data(i_write_data),
        .i_line_in   (i_line_in),
        .i_pop       (item_pop),
        .o_empty     (in_empty),
        .o_item      (item)
    );

    // Back end: advance the bus sequencer one tick per request taken.
    // It stalls only when the result queue has no room.
    owbm_core #(
        .VOTE_SAMPLES (VOTE_SAMPLES),
        .BITS_PER_BYTE(BITS_PER_BYTE),
        .TIMER_BITS   (TIMER_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item),
        .i_item_valid(!in_empty),
        .o_item_pop  (item_pop),
        .o_res       (res),
        .o_res_push  (res_push),
        .i_res_full  (out_full),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Result queue: hold finished results while the consumer stalls.
    owbm_fifo #(
        .WIDTH($bits(t_result))
    ) u_out_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res),
        .o_full (out_full),
        .i_pop  (pop),
        .o_data (out_res),
        .o_empty(empty)
    );

    assign o_line_drive = out_res.line_drive;
    assign o_busy_res   = out_res.busy_res;
    assign o_done_res   = out_res.done_res;
    assign o_presence   = out_res.presence;
    assign o_read_data  = out_res.read_data;

`ifndef ASSERT_OFF
    // The sequencer never pushes a result into a full result queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !out_full)
        else $error("result pushed into full queue");

    // A completing tick always belongs to a running command.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && res.done_res) |-> res.busy_res)
        else $error("done without busy");

    // A waiting request with room downstream is always processed.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_empty && !out_full) |-> (res_push && item_pop))
        else $error("sequencer stalled with work and room");
`endif
endmodule
